/* design/prsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types, constants and pixel formatting for the readout stream decoder.
// ----------------------------------------------------------------------------
package prsd_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_BAD_HEADER = 2'd1,
    KIND_INCOMPLETE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_SECOND = 2'd2
  } phase_t;

  // module-mode qualifiers (word bits 7:4)
  localparam logic [3:0] Q_PIX_FIRST = 4'd1;
  localparam logic [3:0] Q_PIX_NEXT  = 4'd2;
  localparam logic [3:0] Q_PIX_LAST  = 4'd6;
  localparam logic [3:0] Q_CHIP      = 4'd7;
  localparam logic [3:0] Q_HDR_FIRST = 4'd8;
  localparam logic [3:0] Q_HDR_NEXT  = 4'd9;
  localparam logic [3:0] Q_HDR_LAST  = 4'd11;

  // single-chip framing
  localparam logic [15:0] HDR_MASK  = 16'h8FFC;
  localparam logic [15:0] HDR_MATCH = 16'h87F8;
  localparam int          MARK_BIT  = 15;
  localparam logic [7:0]  ROW_BASE  = 8'd80;
  localparam logic [7:0]  CHIP_NONE = 8'hFF;

  // configuration register map (byte address bit 2 selects the register)
  localparam logic REG_MODULE_MODE = 1'b0;

  typedef struct packed {
    logic [23:0] pixel_shift;
    logic        half_toggle;
    logic [7:0]  chip_counter;
    logic [15:0] header_nibbles;
    phase_t      frame_phase;
    logic [11:0] held_half;
    logic        halted;
  } state_t;

  localparam state_t STATE_RESET = '{
    pixel_shift:    24'd0,
    half_toggle:    1'b1,
    chip_counter:   CHIP_NONE,
    header_nibbles: 16'd0,
    frame_phase:    PHASE_HEADER,
    held_half:      12'd0,
    halted:         1'b0
  };

  typedef struct packed {
    kind_t       kind;
    logic        hits;
    logic [7:0]  pulse_height;
    logic [6:0]  column;
    logic [7:0]  row;
    logic [7:0]  chip_index;
    logic        module_half;
    logic [31:0] packed_address;
  } result_t;

  function automatic result_t make_error(kind_t kind);
    result_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  // base-6 address decode of a raw 24-bit pixel word
  function automatic result_t make_pixel(logic [23:0] raw, logic [7:0] chip, logic half);
    result_t     r;
    logic [14:0] a;
    logic [5:0]  dc;
    logic [8:0]  ri;
    logic [6:0]  col;
    logic [7:0]  rowv;
    a    = raw[23:9];
    dc   = 6'({3'b000, a[14:12]} * 6'd6) + {3'b000, a[11:9]};
    ri   = 9'({6'd0, a[8:6]} * 9'd36) + 9'({6'd0, a[5:3]} * 9'd6) + {6'd0, a[2:0]};
    col  = {dc, 1'b0} + {6'd0, ri[0]};
    rowv = ROW_BASE - ri[8:1];
    r.kind           = KIND_PIXEL;
    r.hits           = 1'b1;
    r.pulse_height   = {raw[8:5], raw[3:0]};
    r.column         = col;
    r.row            = rowv;
    r.chip_index     = chip;
    r.module_half    = half;
    r.packed_address = {7'd0, half, chip, 1'b0, col, rowv};
    return r;
  endfunction

endpackage

/* design/pixel_readout_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_readout_stream_decoder
// Decodes 16-bit readout words into pixel hits and framing errors.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  word, last
//   out      source     out_valid/ out_stall kind, hits, pulse_height, column,
//                                            row, chip_index, module_half,
//                                            packed_address
//   cfg      APB slave  psel/penable/pready  module_mode at byte address 0
//
// one item per cycle sustained while in_stall is low; an item waits in the input
// register and its result is loaded into the output register when it advances.
// the decode and running-state update sit between those two registers.
// reset clears the running state, the mode register and both valid flags.
// a stalled result holds the output register; the input register keeps
// advancing for items that give no result, and in_stall rises only when
// the held item needs the output register while it is stalled.
// ----------------------------------------------------------------------------
module pixel_readout_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] word,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        hits,
  output logic [7:0]  pulse_height,
  output logic [6:0]  column,
  output logic signed [7:0] row,
  output logic [7:0]  chip_index,
  output logic        module_half,
  output logic [31:0] packed_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              module_mode;
  logic              s1_valid;
  logic [15:0]       s1_word;
  logic              s1_last;
  prsd_pkg::state_t  state;
  prsd_pkg::state_t  state_next;
  logic              has_result;
  prsd_pkg::result_t result_next;
  prsd_pkg::result_t res;
  logic              advance;
  logic              accept_in;
  logic              out_taken;
  logic              cfg_write;

  prsd_decode u_decode (
    .state       (state),
    .module_mode (module_mode),
    .word        (s1_word),
    .last        (s1_last),
    .state_next  (state_next),
    .has_result  (has_result),
    .result      (result_next)
  );

  assign out_taken = out_valid && !out_stall;
  assign advance   = s1_valid && (!has_result || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == prsd_pkg::REG_MODULE_MODE) ? {31'd0, module_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      state       <= prsd_pkg::STATE_RESET;
      module_mode <= 1'b0;
    end else begin
      if (accept_in) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        state <= state_next;
      end

      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end

      if (cfg_write && paddr[2] == prsd_pkg::REG_MODULE_MODE) begin
        module_mode <= pwdata[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_word <= word;
      s1_last <= last;
    end
    if (advance && has_result) begin
      res <= result_next;
    end
  end

  assign kind           = res.kind;
  assign hits           = res.hits;
  assign pulse_height   = res.pulse_height;
  assign column         = res.column;
  assign row            = res.row;
  assign chip_index     = res.chip_index;
  assign module_half    = res.module_half;
  assign packed_address = res.packed_address;

endmodule

/* design/prsd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsd_decode
// Per-word decode: next running state and the optional result for one item.
// ----------------------------------------------------------------------------
module prsd_decode (
  input  prsd_pkg::state_t  state,
  input  logic              module_mode,
  input  logic [15:0]       word,
  input  logic              last,
  output prsd_pkg::state_t  state_next,
  output logic              has_result,
  output prsd_pkg::result_t result
);

  logic [3:0]  d;
  logic [3:0]  q;
  logic        marked;
  logic [23:0] shift_next;

  assign d          = word[3:0];
  assign q          = word[7:4];
  assign marked     = word[prsd_pkg::MARK_BIT];
  assign shift_next = {state.pixel_shift[19:0], d};

  always_comb begin
    state_next = state;
    has_result = 1'b0;
    result     = prsd_pkg::make_error(prsd_pkg::KIND_PIXEL);

    if (!state.halted) begin
      if (module_mode) begin
        if (q == prsd_pkg::Q_PIX_FIRST) begin
          state_next.pixel_shift = {20'd0, d};
        end else if (q >= prsd_pkg::Q_PIX_NEXT && q <= prsd_pkg::Q_PIX_LAST) begin
          state_next.pixel_shift = shift_next;
          if (q == prsd_pkg::Q_PIX_LAST) begin
            has_result = 1'b1;
            result     = prsd_pkg::make_pixel(shift_next, state.chip_counter,
                                              state.half_toggle);
          end
        end else if (q == prsd_pkg::Q_CHIP) begin
          state_next.chip_counter = state.chip_counter + 8'd1;
        end else if (q == prsd_pkg::Q_HDR_FIRST) begin
          state_next.header_nibbles = {12'd0, d};
        end else if (q >= prsd_pkg::Q_HDR_NEXT && q <= prsd_pkg::Q_HDR_LAST) begin
          state_next.header_nibbles = {state.header_nibbles[11:0], d};
          if (q == prsd_pkg::Q_HDR_LAST) begin
            state_next.half_toggle  = ~state.half_toggle;
            state_next.chip_counter = prsd_pkg::CHIP_NONE;
          end
        end
      end else begin
        if (state.frame_phase == prsd_pkg::PHASE_SECOND) begin
          has_result = 1'b1;
          if (marked) begin
            state_next.halted = 1'b1;
            result            = prsd_pkg::make_error(prsd_pkg::KIND_INCOMPLETE);
          end else begin
            state_next.frame_phase = prsd_pkg::PHASE_FIRST;
            result = prsd_pkg::make_pixel({state.held_half, word[11:0]}, 8'd0, 1'b0);
          end
        end else if (state.frame_phase == prsd_pkg::PHASE_HEADER || marked) begin
          if ((word & prsd_pkg::HDR_MASK) != prsd_pkg::HDR_MATCH) begin
            state_next.halted = 1'b1;
            has_result        = 1'b1;
            result            = prsd_pkg::make_error(prsd_pkg::KIND_BAD_HEADER);
          end else begin
            state_next.frame_phase = prsd_pkg::PHASE_FIRST;
          end
        end else begin
          state_next.held_half   = word[11:0];
          state_next.frame_phase = prsd_pkg::PHASE_SECOND;
          // a first half on the buffer's last word can never be completed
          if (last) begin
            state_next.halted = 1'b1;
            has_result        = 1'b1;
            result            = prsd_pkg::make_error(prsd_pkg::KIND_INCOMPLETE);
          end
        end
      end
    end

    if (last) begin
      state_next = prsd_pkg::STATE_RESET;
    end
  end

endmodule
